// File: rtl/rgbpk_pkg.sv
// Shared types and constants for the RGB to packed pixel byte formatter.
// Depends on nothing; used by rgb_to_packed_pixel_bytes_core.
`timescale 1ns / 1ps

package rgbpk_pkg;

    // Input pixel item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_line;
    } pixel_in_t;

    // One output byte item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_pixel;
        logic        line_done;
        logic [31:0] pixel_word;
    } byte_out_t;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_RED_MASK   = 3'd0,
        REG_GREEN_MASK = 3'd1,
        REG_BLUE_MASK  = 3'd2,
        REG_MSB_FIRST  = 3'd3,
        REG_FOUR_BYTE  = 3'd4,
        REG_GRAY_INPUT = 3'd5
    } reg_index_t;

    localparam int unsigned ADDR_W = 5;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

    // Multiplicative inverse of 255 modulo 2^32, for exact division by 255
    localparam logic [31:0] INV_255 = 32'hFEFE_FEFF;

    localparam int unsigned NUM_CH = 3;

endpackage

// File: rtl/rgb_to_packed_pixel_bytes_core.sv
// Top level of the RGB to packed pixel byte formatter: APB register file,
// scaling pipeline and byte serializer. Depends on rgbpk_pkg.
`timescale 1ns / 1ps

// Usage
//   s_* : one pixel item per handshake (red, green, blue, end_of_line).
//   m_* : one byte item per handshake; 4 or 2 bytes per pixel, LSB or MSB
//         first, last_of_pixel and line_done on the final byte, pixel_word
//         repeated on every byte.
//   APB : six registers at byte addresses 0,4,..,20; pready is tied high.
//         Write only while no pixel is in flight.
// Timing
//   An accepted pixel passes five register stages (input, mask decode,
//   mod-255 residue, exact quotient, products), then loads into the
//   serializer, whose output register offers its first byte.
//   Throughput is set by the byte-wide serializer: four bytes per pixel in
//   four-byte mode, two in two-byte mode; the next pixel loads as the last byte is taken.
// Reset
//   aresetn low clears all stage valids and the serializer and loads the
//   register defaults (8:8:8 masks, LSB first, four bytes, color input).
// Stall
//   While m_ready is low the current byte holds; the pipeline fills behind
//   it and s_ready drops once the last stage holds a waiting pixel.
module rgb_to_packed_pixel_bytes_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    // pixel input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rgbpk_pkg::pixel_in_t       s_data,
    // byte output
    output logic                       m_valid,
    input  logic                       m_ready,
    output rgbpk_pkg::byte_out_t       m_data,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rgbpk_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned NC = rgbpk_pkg::NUM_CH;

    // ---------------- registers ----------------
    logic [31:0] mask_reg [NC];
    logic        msb_first_reg;
    logic        four_byte_reg;
    logic        gray_reg;

    rgbpk_pkg::reg_index_t reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rgbpk_pkg::reg_index_t'(paddr[rgbpk_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg[0]   <= rgbpk_pkg::RED_MASK_RST;
            mask_reg[1]   <= rgbpk_pkg::GREEN_MASK_RST;
            mask_reg[2]   <= rgbpk_pkg::BLUE_MASK_RST;
            msb_first_reg <= 1'b0;
            four_byte_reg <= 1'b1;
            gray_reg      <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                rgbpk_pkg::REG_RED_MASK:   mask_reg[0]   <= pwdata;
                rgbpk_pkg::REG_GREEN_MASK: mask_reg[1]   <= pwdata;
                rgbpk_pkg::REG_BLUE_MASK:  mask_reg[2]   <= pwdata;
                rgbpk_pkg::REG_MSB_FIRST:  msb_first_reg <= pwdata[0];
                rgbpk_pkg::REG_FOUR_BYTE:  four_byte_reg <= pwdata[0];
                rgbpk_pkg::REG_GRAY_INPUT: gray_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rgbpk_pkg::REG_RED_MASK:   prdata = mask_reg[0];
            rgbpk_pkg::REG_GREEN_MASK: prdata = mask_reg[1];
            rgbpk_pkg::REG_BLUE_MASK:  prdata = mask_reg[2];
            rgbpk_pkg::REG_MSB_FIRST:  prdata = {31'd0, msb_first_reg};
            rgbpk_pkg::REG_FOUR_BYTE:  prdata = {31'd0, four_byte_reg};
            rgbpk_pkg::REG_GRAY_INPUT: prdata = {31'd0, gray_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // lowest set bit of a mask, 0 for an empty mask
    function automatic logic [4:0] low_bit(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) s = 5'(i);
        end
        return s;
    endfunction

    // ---------------- pipeline ----------------
    logic        pipe_en;
    logic        load;

    // input stage
    logic        in_v_reg;
    logic [7:0]  in_samp_reg [NC];
    logic        in_eol_reg;
    // stage A: shift and field maximum
    logic        a_v_reg;
    logic [7:0]  a_samp_reg [NC];
    logic [4:0]  a_sh_reg   [NC];
    logic [31:0] a_top_reg  [NC];
    logic        a_eol_reg;
    // stage B: residue mod 255
    logic        b_v_reg;
    logic [7:0]  b_samp_reg [NC];
    logic [4:0]  b_sh_reg   [NC];
    logic [31:0] b_top_reg  [NC];
    logic [7:0]  b_rem_reg  [NC];
    logic        b_eol_reg;
    // stage C: quotient top / 255
    logic        c_v_reg;
    logic [7:0]  c_samp_reg [NC];
    logic [4:0]  c_sh_reg   [NC];
    logic [7:0]  c_rem_reg  [NC];
    logic [31:0] c_q_reg    [NC];
    logic        c_eol_reg;
    // stage D: products
    logic        d_v_reg;
    logic [4:0]  d_sh_reg   [NC];
    logic [31:0] d_pq_reg   [NC];
    logic [15:0] d_pr_reg   [NC];
    logic        d_eol_reg;

    logic [7:0]  samp_in [NC];
    logic [9:0]  byte_sum [NC];
    logic [8:0]  fold [NC];
    logic [7:0]  rem_next [NC];
    logic [16:0] fix_sum [NC];
    logic [31:0] scaled [NC];
    logic [31:0] word_next;

    assign pipe_en = !d_v_reg || load;
    assign s_ready = pipe_en;

    always_comb begin
        samp_in[0] = s_data.red;
        samp_in[1] = gray_reg ? s_data.red : s_data.green;
        samp_in[2] = gray_reg ? s_data.red : s_data.blue;
        word_next  = 32'd0;
        for (int c = 0; c < NC; c++) begin
            // top = sum of bytes (mod 255) since 256 == 1 (mod 255)
            byte_sum[c] = {2'd0, a_top_reg[c][7:0]}   + {2'd0, a_top_reg[c][15:8]}
                        + {2'd0, a_top_reg[c][23:16]} + {2'd0, a_top_reg[c][31:24]};
            fold[c]     = {1'b0, byte_sum[c][7:0]} + {7'd0, byte_sum[c][9:8]};
            rem_next[c] = (fold[c] >= 9'd255) ? 8'(fold[c] - 9'd255) : fold[c][7:0];
            // floor(p / 255) for p up to 255 * 255, the largest product of two bytes
            fix_sum[c]  = {1'b0, d_pr_reg[c]} + 17'd1 + {9'd0, d_pr_reg[c][15:8]};
            scaled[c]   = d_pq_reg[c] + {24'd0, fix_sum[c][15:8]};
            word_next   = word_next | (scaled[c] << d_sh_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            d_v_reg  <= 1'b0;
        end else if (pipe_en) begin
            in_v_reg <= s_valid;
            a_v_reg  <= in_v_reg;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            d_v_reg  <= c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in_eol_reg <= s_data.end_of_line;
            a_eol_reg  <= in_eol_reg;
            b_eol_reg  <= a_eol_reg;
            c_eol_reg  <= b_eol_reg;
            d_eol_reg  <= c_eol_reg;
            for (int c = 0; c < NC; c++) begin
                in_samp_reg[c] <= samp_in[c];

                a_samp_reg[c]  <= in_samp_reg[c];
                a_sh_reg[c]    <= low_bit(mask_reg[c]);
                a_top_reg[c]   <= mask_reg[c] >> low_bit(mask_reg[c]);

                b_samp_reg[c]  <= a_samp_reg[c];
                b_sh_reg[c]    <= a_sh_reg[c];
                b_top_reg[c]   <= a_top_reg[c];
                b_rem_reg[c]   <= rem_next[c];

                c_samp_reg[c]  <= b_samp_reg[c];
                c_sh_reg[c]    <= b_sh_reg[c];
                c_rem_reg[c]   <= b_rem_reg[c];
                // exact: top - rem is a multiple of 255
                c_q_reg[c]     <= 32'((b_top_reg[c] - {24'd0, b_rem_reg[c]})
                                      * rgbpk_pkg::INV_255);

                d_sh_reg[c]    <= c_sh_reg[c];
                d_pq_reg[c]    <= 32'({24'd0, c_samp_reg[c]} * c_q_reg[c]);
                d_pr_reg[c]    <= 16'({8'd0, c_samp_reg[c]} * {8'd0, c_rem_reg[c]});
            end
        end
    end

    // ---------------- byte serializer ----------------
    logic        out_v_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] word_reg;
    logic        eol_reg;
    logic [1:0]  last_idx;
    logic [1:0]  pos;
    logic        is_last;

    assign last_idx = four_byte_reg ? 2'd3 : 2'd1;
    assign is_last  = (cnt_reg == last_idx);
    assign pos      = msb_first_reg ? 2'(last_idx - cnt_reg) : cnt_reg;
    assign load     = d_v_reg && (!out_v_reg || (m_ready && is_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end else if (load) begin
            out_v_reg <= 1'b1;
            cnt_reg   <= 2'd0;
        end else if (out_v_reg && m_ready) begin
            if (is_last) begin
                out_v_reg <= 1'b0;
                cnt_reg   <= 2'd0;
            end else begin
                cnt_reg   <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
            eol_reg  <= d_eol_reg;
        end
    end

    assign m_valid              = out_v_reg;
    assign m_data.out_byte      = 8'(word_reg >> {pos, 3'd0});
    assign m_data.last_of_pixel = is_last;
    assign m_data.line_done     = is_last && eol_reg;
    assign m_data.pixel_word    = word_reg;

endmodule

// File: tb/sv/tb.sv
// Testbench for rgb_to_packed_pixel_bytes_core: drives pixel items, predicts
// the packed byte stream and checks every byte; registers are written over APB.
// Depends on rgbpk_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 65;
    localparam int unsigned MAX_GAP         = 20;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    rgbpk_pkg::pixel_in_t          s_data  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    rgbpk_pkg::byte_out_t          m_data;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [rgbpk_pkg::ADDR_W-1:0]  paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Local copy of the register file
    logic [31:0] red_mask_cfg   = rgbpk_pkg::RED_MASK_RST;
    logic [31:0] green_mask_cfg = rgbpk_pkg::GREEN_MASK_RST;
    logic [31:0] blue_mask_cfg  = rgbpk_pkg::BLUE_MASK_RST;
    logic        msb_first_cfg  = 1'b0;
    logic        four_byte_cfg  = 1'b1;
    logic        gray_cfg       = 1'b0;

    rgbpk_pkg::byte_out_t pending_bytes[$];
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_token   = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rgb_to_packed_pixel_bytes_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // floor(sample * (mask >> shift) / 255) moved back up by the shift
    function automatic logic [31:0] scale_channel(input logic [7:0] sample,
                                                  input logic [31:0] mask);
        int unsigned sh;
        logic [63:0] scaled;
        sh = 0;
        if (mask != 32'd0) begin
            while (!mask[sh]) sh++;
        end
        scaled = (64'(sample) * 64'(mask >> sh)) / 64'd255;
        return 32'(scaled << sh);
    endfunction

    function automatic void queue_pixel_bytes(input rgbpk_pkg::pixel_in_t px);
        logic [7:0]           g;
        logic [7:0]           b;
        logic [31:0]          word;
        int                   n;
        int                   pos;
        rgbpk_pkg::byte_out_t exp_byte;
        g = gray_cfg ? px.red : px.green;
        b = gray_cfg ? px.red : px.blue;
        word = scale_channel(px.red, red_mask_cfg) | scale_channel(g, green_mask_cfg)
             | scale_channel(b, blue_mask_cfg);
        n = four_byte_cfg ? 4 : 2;
        for (int k = 0; k < n; k++) begin
            pos = msb_first_cfg ? (n - 1 - k) : k;
            exp_byte.out_byte      = word[pos*8 +: 8];
            exp_byte.last_of_pixel = (k == n - 1);
            exp_byte.line_done     = (k == n - 1) && px.end_of_line;
            exp_byte.pixel_word    = word;
            pending_bytes.push_back(exp_byte);
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever hold_token moves
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h, nothing expected", $time,
                         m_data.out_byte);
                error_count++;
            end else begin
                rgbpk_pkg::byte_out_t exp_byte;
                exp_byte = pending_bytes.pop_front();
                if (m_data.out_byte !== exp_byte.out_byte) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             exp_byte.out_byte, m_data.out_byte);
                    error_count++;
                end
                if (m_data.last_of_pixel !== exp_byte.last_of_pixel) begin
                    $display("%0t: last_of_pixel expected %0b actual %0b", $time,
                             exp_byte.last_of_pixel, m_data.last_of_pixel);
                    error_count++;
                end
                if (m_data.line_done !== exp_byte.line_done) begin
                    $display("%0t: line_done expected %0b actual %0b", $time,
                             exp_byte.line_done, m_data.line_done);
                    error_count++;
                end
                if (m_data.pixel_word !== exp_byte.pixel_word) begin
                    $display("%0t: pixel_word expected %08h actual %08h", $time,
                             exp_byte.pixel_word, m_data.pixel_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one item, hold it until accepted, then maybe go idle a while
    task automatic send_pixel(input rgbpk_pkg::pixel_in_t px);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queue_pixel_bytes(px);
        gap = 0;
        while (($urandom_range(99) < tx_idle_pct) && (gap < MAX_GAP)) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic eol);
        rgbpk_pkg::pixel_in_t px;
        px.red         = r;
        px.green       = g;
        px.blue        = b;
        px.end_of_line = eol;
        send_pixel(px);
    endtask

    // Stop offering, let all expected bytes out and the pipeline empty
    task automatic wait_drained;
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write then read back one register, as two back-to-back transfers
    task automatic apb_write(input rgbpk_pkg::reg_index_t idx, input logic [31:0] value);
        logic [31:0] readback;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rgbpk_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rgbpk_pkg::REG_RED_MASK:   red_mask_cfg   = value;
            rgbpk_pkg::REG_GREEN_MASK: green_mask_cfg = value;
            rgbpk_pkg::REG_BLUE_MASK:  blue_mask_cfg  = value;
            rgbpk_pkg::REG_MSB_FIRST:  msb_first_cfg  = value[0];
            rgbpk_pkg::REG_FOUR_BYTE:  four_byte_cfg  = value[0];
            rgbpk_pkg::REG_GRAY_INPUT: gray_cfg       = value[0];
            default: ;
        endcase
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value) begin
            $display("%0t: register %0d readback expected %08h actual %08h", $time,
                     idx, value, readback);
            error_count++;
        end
    endtask

    task automatic apply_format(input logic [31:0] rmask, input logic [31:0] gmask,
                                input logic [31:0] bmask, input logic msb,
                                input logic four, input logic gray);
        wait_drained();
        apb_write(rgbpk_pkg::REG_RED_MASK, rmask);
        apb_write(rgbpk_pkg::REG_GREEN_MASK, gmask);
        apb_write(rgbpk_pkg::REG_BLUE_MASK, bmask);
        apb_write(rgbpk_pkg::REG_MSB_FIRST, 32'(msb));
        apb_write(rgbpk_pkg::REG_FOUR_BYTE, 32'(four));
        apb_write(rgbpk_pkg::REG_GRAY_INPUT, 32'(gray));
    endtask

    function automatic logic [31:0] random_mask();
        int unsigned w;
        int unsigned off;
        case ($urandom_range(5))
            0: begin
                w   = $urandom_range(1, 32);
                off = $urandom_range(0, 32 - w);
                return 32'(((64'd1 << w) - 64'd1) << off);
            end
            1: return $urandom;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'd1 << $urandom_range(31);
            default: begin
                w   = $urandom_range(4, 8);
                off = 8 * $urandom_range(0, 3);
                return 32'(((64'd1 << w) - 64'd1) << off);
            end
        endcase
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_default_format;
        tx_idle_pct  = 22;
        rx_stall_pct = 22;
        send_rgb(8'h00, 8'h00, 8'h00, 1'b0);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_rgb(8'h80, 8'h01, 8'hAA, 1'b0);
        send_rgb(8'h55, 8'h7F, 8'hFE, 1'b1);
    endtask

    task automatic test_byte_order;
        apply_format(rgbpk_pkg::RED_MASK_RST, rgbpk_pkg::GREEN_MASK_RST,
                     rgbpk_pkg::BLUE_MASK_RST, 1'b1, 1'b1, 1'b0);
        send_rgb(8'h12, 8'h34, 8'h56, 1'b1);
        send_rgb(8'hFF, 8'h00, 8'hFF, 1'b0);
        // two-byte mode drops the top half from the byte stream only
        apply_format(rgbpk_pkg::RED_MASK_RST, rgbpk_pkg::GREEN_MASK_RST,
                     rgbpk_pkg::BLUE_MASK_RST, 1'b0, 1'b0, 1'b0);
        send_rgb(8'hC3, 8'h3C, 8'h5A, 1'b1);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b0);
        apply_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b1, 1'b0, 1'b0);
        send_rgb(8'hFF, 8'h80, 8'h01, 1'b1);
        send_rgb(8'h7F, 8'hFF, 8'hFE, 1'b0);
    endtask

    task automatic test_mask_corners;
        // zero red mask contributes nothing
        apply_format(32'd0, rgbpk_pkg::GREEN_MASK_RST, rgbpk_pkg::BLUE_MASK_RST,
                     1'b0, 1'b1, 1'b0);
        send_rgb(8'hFF, 8'h81, 8'h42, 1'b0);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b1);
        // holes in the mask may be filled by the scaled value
        apply_format(32'h0A50_0000, 32'h0000_0F0F, 32'h8000_0081, 1'b1, 1'b1, 1'b0);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_rgb(8'h9C, 8'h63, 8'h01, 1'b0);
        // overlapping fields are ORed
        apply_format(32'hFFFF_0000, 32'h00FF_FF00, 32'h0000_FFFF, 1'b0, 1'b1, 1'b0);
        send_rgb(8'hA5, 8'h5A, 8'hC3, 1'b0);
        send_rgb(8'h01, 8'hFE, 8'h80, 1'b1);
        // full-width mask and single top bit
        apply_format(32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        send_rgb(8'hFF, 8'h00, 8'hFF, 1'b1);
        send_rgb(8'h7F, 8'hFF, 8'h80, 1'b0);
    endtask

    task automatic test_gray_input;
        apply_format(rgbpk_pkg::RED_MASK_RST, rgbpk_pkg::GREEN_MASK_RST,
                     rgbpk_pkg::BLUE_MASK_RST, 1'b0, 1'b1, 1'b1);
        send_rgb(8'hFF, 8'h00, 8'h12, 1'b0);
        send_rgb(8'h00, 8'hFF, 8'hFF, 1'b1);
        send_rgb(8'h80, 8'h3C, 8'hC3, 1'b0);
    endtask

    task automatic test_random_formats;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_format(random_mask(), random_mask(), random_mask(),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_rgb(random_sample(), random_sample(), random_sample(),
                         ($urandom_range(3) == 0));
            end
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_input_stall;
        apply_format(rgbpk_pkg::RED_MASK_RST, rgbpk_pkg::GREEN_MASK_RST,
                     rgbpk_pkg::BLUE_MASK_RST, 1'b0, 1'b1, 1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_token  <= hold_token + 1;
        for (int i = 0; i < 40; i++) begin
            send_rgb(random_sample(), random_sample(), random_sample(),
                     ($urandom_range(3) == 0));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_format();
        test_byte_order();
        test_mask_corners();
        test_gray_input();
        test_random_formats();
        test_input_stall();
        wait_drained();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
